### design/c8rtu_pkg.sv
// ============================================================================
// c8rtu_pkg
// Shared types and constants of the CHIP-8 register transfer unit.
// ============================================================================
package c8rtu_pkg;

  // Default geometry
  localparam int MEM_DEPTH_DEF = 4096;
  localparam int FONT_BASE_DEF = 80;

  // Fixed field widths
  localparam int ADDR_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int NIB_W    = 4;
  localparam int WORD_W   = 16;
  localparam int FUNC_W   = 4;
  localparam int DEST_W   = 2;

  // Register file: V0..VF in the lower half, flag bytes in the upper half
  localparam int RF_DEPTH = 32;
  localparam int RF_AW    = 5;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SETREG = 4'd0,
    FUNC_SETIDX = 4'd1,
    FUNC_DUMP   = 4'd2,
    FUNC_DUMPN  = 4'd3,
    FUNC_LOAD   = 4'd4,
    FUNC_LOADN  = 4'd5,
    FUNC_MOVE   = 4'd6,
    FUNC_FONT   = 4'd7,
    FUNC_PDUMP  = 4'd8,
    FUNC_PLOAD  = 4'd9,
    FUNC_HOST   = 4'd10
  } func_e;

  // Result destination codes
  typedef enum logic [DEST_W-1:0] {
    DEST_REG  = 2'd0,
    DEST_MEM  = 2'd1,
    DEST_FLAG = 2'd2,
    DEST_IDX  = 2'd3
  } dest_e;

  // Access request to the register file
  typedef struct packed {
    logic              we;
    logic [RF_AW-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [RF_AW-1:0]  raddr;
  } rf_req_t;

endpackage

### design/c8rtu_ram.sv
// ============================================================================
// c8rtu_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module c8rtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/c8rtu_regfile.sv
// ============================================================================
// c8rtu_regfile
// General registers and flag bytes in one RAM; per-entry valid bits make
// never-written entries read as zero after reset.
// ============================================================================
module c8rtu_regfile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  c8rtu_pkg::rf_req_t             req_i,
  output logic [c8rtu_pkg::BYTE_W-1:0]   rdata_o
);
  import c8rtu_pkg::*;

  logic [RF_DEPTH-1:0] valid_q;
  logic                rvalid_q;
  logic [BYTE_W-1:0]   ram_rdata;

  c8rtu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RF_DEPTH),
    .AW    (RF_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  // Mark entries written, track validity of the word being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rvalid_q <= valid_q[req_i.raddr];
    end
  end

  // Mask stale RAM contents of entries never written
  assign rdata_o = rvalid_q ? ram_rdata : '0;

`ifndef NO_ASSERTIONS
  // A read never targets the entry written in the same cycle
  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.we && req_i.re) |-> (req_i.waddr != req_i.raddr))
    else $error("register file read and write collide");
`endif

endmodule

### design/c8rtu_ctrl.sv
// ============================================================================
// c8rtu_ctrl
// Sequencer: memory clear sweep, read issue stage, write-back stage,
// index register and result register.
// ============================================================================
module c8rtu_ctrl #(
  parameter int MEM_DEPTH = c8rtu_pkg::MEM_DEPTH_DEF,
  parameter int FONT_BASE = c8rtu_pkg::FONT_BASE_DEF,
  parameter int MEM_AW    = $clog2(MEM_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [c8rtu_pkg::FUNC_W-1:0]   func_i,
  input  logic [c8rtu_pkg::WORD_W-1:0]   instr_word_i,
  input  logic [c8rtu_pkg::ADDR_W-1:0]   host_addr_i,
  input  logic [c8rtu_pkg::BYTE_W-1:0]   host_data_i,
  output c8rtu_pkg::rf_req_t             rf_req_o,
  input  logic [c8rtu_pkg::BYTE_W-1:0]   rf_rdata_i,
  output logic                           mem_we_o,
  output logic [MEM_AW-1:0]              mem_waddr_o,
  output logic [c8rtu_pkg::BYTE_W-1:0]   mem_wdata_o,
  output logic [MEM_AW-1:0]              mem_raddr_o,
  input  logic [c8rtu_pkg::BYTE_W-1:0]   mem_rdata_i,
  output logic                           result_valid_o,
  output logic [c8rtu_pkg::DEST_W-1:0]   dest_o,
  output logic [c8rtu_pkg::NIB_W-1:0]    reg_num_o,
  output logic [c8rtu_pkg::BYTE_W-1:0]   value_o,
  output logic [c8rtu_pkg::ADDR_W-1:0]   mem_addr_o,
  output logic [c8rtu_pkg::ADDR_W-1:0]   index_value_o,
  output logic                           last_o
);
  import c8rtu_pkg::*;

  // Reduction of a 12-bit address to a cell: four compare-subtract steps
  localparam int CELL_W = MEM_AW + 4;
  localparam logic [CELL_W-1:0] DEPTH_V  = CELL_W'(MEM_DEPTH);
  localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_DEPTH - 1);
  localparam logic [ADDR_W-1:0] FONT_V   = ADDR_W'(FONT_BASE);

  function automatic logic [MEM_AW-1:0] cell_of(input logic [ADDR_W-1:0] addr);
    logic [CELL_W-1:0] v;
    v = CELL_W'(addr);
    for (int k = 3; k >= 0; k--) begin
      if (v >= (DEPTH_V << k)) begin
        v = v - (DEPTH_V << k);
      end
    end
    return v[MEM_AW-1:0];
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [MEM_AW-1:0]   clr_addr_q;

  // Item latched when a valid function code is accepted
  func_e               func_q;
  logic [NIB_W-1:0]    x_q, y_q;
  logic [BYTE_W-1:0]   nn_q;
  logic [ADDR_W-1:0]   host_addr_q;
  logic [BYTE_W-1:0]   host_data_q;
  logic [ADDR_W-1:0]   base_q;
  logic [ADDR_W-1:0]   index_q, index_d;

  // Issue stage
  logic [NIB_W-1:0]    i_q;
  logic                multi;
  logic                a_last;
  logic [ADDR_W-1:0]   a_addr;
  logic                run;
  logic                rd_re;
  logic [RF_AW-1:0]    rd_addr;

  // Write-back stage
  logic                b_v_q;
  logic [NIB_W-1:0]    b_i_q;
  logic                b_last_q;
  logic [ADDR_W-1:0]   b_a_q;
  logic [MEM_AW-1:0]   b_cell_q;

  logic                accept, go;
  logic                font_wr;
  logic [ADDR_W-1:0]   font_addr;
  logic [ADDR_W-1:0]   idx_cur;
  logic                b_mem_we;
  logic [BYTE_W-1:0]   b_mem_wdata;

  // Result register
  logic                out_valid_q;
  dest_e               out_dest_q, o_dest;
  logic [NIB_W-1:0]    out_reg_q, o_reg;
  logic [BYTE_W-1:0]   out_val_q, o_val;
  logic [ADDR_W-1:0]   out_addr_q, o_addr;
  logic [ADDR_W-1:0]   out_idx_q, o_idx;
  logic                out_last_q;

  assign run    = (state_q == ST_RUN);
  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && (state_q == ST_IDLE);
  assign go     = accept && (func_i <= FUNC_HOST);

  // Issue stage: element address, end of walk, read requests
  always_comb begin
    multi = 1'b0;
    case (func_q)
      FUNC_DUMP, FUNC_DUMPN, FUNC_LOAD, FUNC_LOADN, FUNC_PDUMP, FUNC_PLOAD: begin
        multi = 1'b1;
      end
      default: multi = 1'b0;
    endcase
  end

  assign a_last = multi ? (i_q == x_q) : 1'b1;
  assign a_addr = (func_q == FUNC_HOST) ? host_addr_q : (base_q + ADDR_W'(i_q));
  assign mem_raddr_o = cell_of(a_addr);

  always_comb begin
    rd_re   = 1'b0;
    rd_addr = '0;
    case (func_q)
      FUNC_DUMP, FUNC_DUMPN, FUNC_PDUMP: begin
        rd_re   = run;
        rd_addr = {1'b0, i_q};
      end
      FUNC_MOVE: begin
        rd_re   = run;
        rd_addr = {1'b0, y_q};
      end
      FUNC_FONT: begin
        rd_re   = run;
        rd_addr = {1'b0, x_q};
      end
      FUNC_PLOAD: begin
        rd_re   = run;
        rd_addr = {1'b1, i_q};
      end
      default: ;
    endcase
  end

  // Font sprite address from the low digit of VX
  assign font_addr = FONT_V + {6'b0, rf_rdata_i[NIB_W-1:0], 2'b00}
                   + {8'b0, rf_rdata_i[NIB_W-1:0]};

  // Write-back stage: perform the write and build the result word
  always_comb begin
    rf_req_o.re    = rd_re;
    rf_req_o.raddr = rd_addr;
    rf_req_o.we    = 1'b0;
    rf_req_o.waddr = '0;
    rf_req_o.wdata = '0;
    b_mem_we       = 1'b0;
    b_mem_wdata    = rf_rdata_i;
    font_wr        = 1'b0;
    o_dest         = DEST_REG;
    o_reg          = '0;
    o_val          = '0;
    o_addr         = '0;
    if (b_v_q) begin
      case (func_q)
        FUNC_SETREG: begin
          rf_req_o.we    = 1'b1;
          rf_req_o.waddr = {1'b0, x_q};
          rf_req_o.wdata = nn_q;
          o_reg          = x_q;
          o_val          = nn_q;
        end
        FUNC_SETIDX: begin
          o_dest = DEST_IDX;
        end
        FUNC_DUMP, FUNC_DUMPN: begin
          b_mem_we = 1'b1;
          o_dest   = DEST_MEM;
          o_reg    = b_i_q;
          o_val    = rf_rdata_i;
          o_addr   = b_a_q;
        end
        FUNC_LOAD, FUNC_LOADN: begin
          rf_req_o.we    = 1'b1;
          rf_req_o.waddr = {1'b0, b_i_q};
          rf_req_o.wdata = mem_rdata_i;
          o_reg          = b_i_q;
          o_val          = mem_rdata_i;
        end
        FUNC_MOVE: begin
          rf_req_o.we    = 1'b1;
          rf_req_o.waddr = {1'b0, x_q};
          rf_req_o.wdata = rf_rdata_i;
          o_reg          = x_q;
          o_val          = rf_rdata_i;
        end
        FUNC_FONT: begin
          font_wr = 1'b1;
          o_dest  = DEST_IDX;
          o_reg   = x_q;
        end
        FUNC_PDUMP: begin
          rf_req_o.we    = 1'b1;
          rf_req_o.waddr = {1'b1, b_i_q};
          rf_req_o.wdata = rf_rdata_i;
          o_dest         = DEST_FLAG;
          o_reg          = b_i_q;
          o_val          = rf_rdata_i;
        end
        FUNC_PLOAD: begin
          rf_req_o.we    = 1'b1;
          rf_req_o.waddr = {1'b0, b_i_q};
          rf_req_o.wdata = rf_rdata_i;
          o_reg          = b_i_q;
          o_val          = rf_rdata_i;
        end
        FUNC_HOST: begin
          b_mem_we    = 1'b1;
          b_mem_wdata = host_data_q;
          o_dest      = DEST_MEM;
          o_val       = host_data_q;
          o_addr      = b_a_q;
        end
        default: ;
      endcase
    end
  end

  // Index forwarding: a font result lands in the same cycle as a new accept
  assign idx_cur = font_wr ? font_addr : index_q;
  assign o_idx   = idx_cur;

  always_comb begin
    index_d = idx_cur;
    if (go) begin
      case (func_e'(func_i))
        FUNC_SETIDX:          index_d = instr_word_i[ADDR_W-1:0];
        FUNC_DUMP, FUNC_LOAD: index_d = idx_cur + ADDR_W'(instr_word_i[11:8]) + ADDR_W'(1);
        default:              index_d = idx_cur;
      endcase
    end
  end

  // Memory port: clear sweep or write-back
  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = clr_addr_q;
      mem_wdata_o = '0;
    end else begin
      mem_we_o    = b_mem_we;
      mem_waddr_o = b_cell_q;
      mem_wdata_o = b_mem_wdata;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_addr_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE:  if (go) state_d = ST_RUN;
      ST_RUN:   if (a_last) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      index_q     <= '0;
      i_q         <= '0;
      b_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      index_q     <= index_d;
      b_v_q       <= run;
      out_valid_q <= b_v_q;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + MEM_AW'(1);
      end
      if (go) begin
        i_q <= '0;
      end else if (run) begin
        i_q <= i_q + NIB_W'(1);
      end
    end
  end

  // Item and pipeline payload
  always_ff @(posedge clk_i) begin
    if (go) begin
      func_q      <= func_e'(func_i);
      x_q         <= instr_word_i[11:8];
      y_q         <= instr_word_i[7:4];
      nn_q        <= instr_word_i[7:0];
      host_addr_q <= host_addr_i;
      host_data_q <= host_data_i;
      base_q      <= idx_cur;
    end
    b_i_q      <= i_q;
    b_last_q   <= a_last;
    b_a_q      <= a_addr;
    b_cell_q   <= mem_raddr_o;
    out_dest_q <= o_dest;
    out_reg_q  <= o_reg;
    out_val_q  <= o_val;
    out_addr_q <= o_addr;
    out_idx_q  <= o_idx;
    out_last_q <= b_last_q;
  end

  assign result_valid_o = out_valid_q;
  assign dest_o         = out_dest_q;
  assign reg_num_o      = out_reg_q;
  assign value_o        = out_val_q;
  assign mem_addr_o     = out_addr_q;
  assign index_value_o  = out_idx_q;
  assign last_o         = out_last_q;

`ifndef NO_ASSERTIONS
  // No write-back may run while the memory is being cleared
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !b_v_q)
    else $error("write-back during memory clear");

  // An accepted operation starts its walk at element zero
  a_go_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (state_q == ST_RUN) && (i_q == '0))
    else $error("accepted operation did not start");

  // Write-back never passes the last register of the walk
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_v_q |-> (b_i_q <= x_q))
    else $error("element index beyond X");

  // The final write-back happens with the issue stage already idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_v_q && b_last_q) |-> (state_q == ST_IDLE))
    else $error("issue stage still active at final write-back");
`endif

endmodule

### design/chip8_register_transfer_unit.sv
// ============================================================================
// chip8_register_transfer_unit
// CHIP-8 assignment and transfer instructions on V0..VF, I, memory and flags.
// ============================================================================
// Usage:
//   Command channel: an item (func_i, instr_word_i, host_addr_i, host_data_i)
//   is taken at a clock edge where start is high and busy is low. Function
//   codes above host write are taken and dropped without any result.
//   Result channel: each register, memory or flag write (or index-only
//   update) appears for one cycle with result_valid_o high; last_o marks the
//   final word of an item. The receiver cannot stall; words are never held.
//   Timing: an item with N writes (N = X+1 for dump/load and flag dump/load,
//   else 1) keeps busy high while its elements issue, one per cycle; the
//   next item may be taken in the cycle after. Results trail issue by the
//   registered read of the register file or memory and then by the result
//   register. Reset: registers, flags and I read as zero at once; the
//   memory is cleared by a sweep, one entry per cycle, during which busy
//   stays high.
// ============================================================================
module chip8_register_transfer_unit #(
  parameter int MEM_DEPTH = c8rtu_pkg::MEM_DEPTH_DEF,
  parameter int FONT_BASE = c8rtu_pkg::FONT_BASE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [c8rtu_pkg::FUNC_W-1:0]   func_i,
  input  logic [c8rtu_pkg::WORD_W-1:0]   instr_word_i,
  input  logic [c8rtu_pkg::ADDR_W-1:0]   host_addr_i,
  input  logic [c8rtu_pkg::BYTE_W-1:0]   host_data_i,
  output logic                           result_valid_o,
  output logic [c8rtu_pkg::DEST_W-1:0]   dest_o,
  output logic [c8rtu_pkg::NIB_W-1:0]    reg_num_o,
  output logic [c8rtu_pkg::BYTE_W-1:0]   value_o,
  output logic [c8rtu_pkg::ADDR_W-1:0]   mem_addr_o,
  output logic [c8rtu_pkg::ADDR_W-1:0]   index_value_o,
  output logic                           last_o
);
  import c8rtu_pkg::*;

  localparam int MEM_AW = $clog2(MEM_DEPTH);

  rf_req_t             rf_req;
  logic [BYTE_W-1:0]   rf_rdata;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr;
  logic [BYTE_W-1:0]   mem_wdata;
  logic [MEM_AW-1:0]   mem_raddr;
  logic [BYTE_W-1:0]   mem_rdata;

  // Sequencer
  c8rtu_ctrl #(
    .MEM_DEPTH (MEM_DEPTH),
    .FONT_BASE (FONT_BASE),
    .MEM_AW    (MEM_AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .func_i         (func_i),
    .instr_word_i   (instr_word_i),
    .host_addr_i    (host_addr_i),
    .host_data_i    (host_data_i),
    .rf_req_o       (rf_req),
    .rf_rdata_i     (rf_rdata),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .dest_o         (dest_o),
    .reg_num_o      (reg_num_o),
    .value_o        (value_o),
    .mem_addr_o     (mem_addr_o),
    .index_value_o  (index_value_o),
    .last_o         (last_o)
  );

  // General registers and flag bytes
  c8rtu_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rf_req),
    .rdata_o (rf_rdata)
  );

  // Main memory
  c8rtu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### dv/chip8_register_transfer_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// chip8_register_transfer_checker
// Watches the command and result channels of the CHIP-8 register transfer
// unit. It keeps its own copy of V0..VF, I, memory and the flag bytes, works
// out the result words that each accepted command produces, and compares
// every result word against the oldest outstanding prediction.
// ============================================================================
module chip8_register_transfer_checker #(
  parameter int MEM_DEPTH = c8rtu_pkg::MEM_DEPTH_DEF,
  parameter int FONT_BASE = c8rtu_pkg::FONT_BASE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [c8rtu_pkg::FUNC_W-1:0] func_i,
  input  logic [c8rtu_pkg::WORD_W-1:0] instr_word_i,
  input  logic [c8rtu_pkg::ADDR_W-1:0] host_addr_i,
  input  logic [c8rtu_pkg::BYTE_W-1:0] host_data_i,
  input  logic                         result_valid_i,
  input  logic [c8rtu_pkg::DEST_W-1:0] dest_i,
  input  logic [c8rtu_pkg::NIB_W-1:0]  reg_num_i,
  input  logic [c8rtu_pkg::BYTE_W-1:0] value_i,
  input  logic [c8rtu_pkg::ADDR_W-1:0] mem_addr_i,
  input  logic [c8rtu_pkg::ADDR_W-1:0] index_value_i,
  input  logic                         last_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import c8rtu_pkg::*;

  localparam int MAX_REPORTS = 10;

  // One reported write
  typedef struct packed {
    dest_e             dest;
    logic [NIB_W-1:0]  reg_num;
    logic [BYTE_W-1:0] value;
    logic [ADDR_W-1:0] mem_addr;
    logic [ADDR_W-1:0] index_value;
    logic              last;
  } write_rec_t;

  // Shadow machine state
  logic [BYTE_W-1:0] vregs [16];
  logic [ADDR_W-1:0] index_reg;
  logic [BYTE_W-1:0] memory [MEM_DEPTH];
  logic [BYTE_W-1:0] pflags [16];

  write_rec_t expected_writes [$];

  function automatic write_rec_t make_write(dest_e d, logic [NIB_W-1:0] r,
                                            logic [BYTE_W-1:0] v,
                                            logic [ADDR_W-1:0] a);
    write_rec_t w;
    w.dest        = d;
    w.reg_num     = r;
    w.value       = v;
    w.mem_addr    = a;
    w.index_value = '0;
    w.last        = 1'b0;
    return w;
  endfunction

  // Apply one command to the shadow state and queue the writes it reports
  task automatic predict_writes(input logic [FUNC_W-1:0] fn,
                                input logic [WORD_W-1:0] word,
                                input logic [ADDR_W-1:0] haddr,
                                input logic [BYTE_W-1:0] hdata);
    write_rec_t        batch [$];
    write_rec_t        w;
    logic [NIB_W-1:0]  x;
    logic [NIB_W-1:0]  y;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] a;
    int                k;
    x    = word[11:8];
    y    = word[7:4];
    base = index_reg;
    case (fn)
      FUNC_SETREG: begin
        vregs[x] = word[7:0];
        batch.push_back(make_write(DEST_REG, x, word[7:0], '0));
      end
      FUNC_SETIDX: begin
        index_reg = word[11:0];
        batch.push_back(make_write(DEST_IDX, '0, '0, '0));
      end
      FUNC_DUMP, FUNC_DUMPN: begin
        for (k = 0; k <= x; k++) begin
          a = base + ADDR_W'(k);
          memory[a % MEM_DEPTH] = vregs[k];
          batch.push_back(make_write(DEST_MEM, NIB_W'(k), vregs[k], a));
        end
        if (fn == FUNC_DUMP) index_reg = base + ADDR_W'(x) + 1'b1;
      end
      FUNC_LOAD, FUNC_LOADN: begin
        for (k = 0; k <= x; k++) begin
          a = base + ADDR_W'(k);
          vregs[k] = memory[a % MEM_DEPTH];
          batch.push_back(make_write(DEST_REG, NIB_W'(k), vregs[k], '0));
        end
        if (fn == FUNC_LOAD) index_reg = base + ADDR_W'(x) + 1'b1;
      end
      FUNC_MOVE: begin
        vregs[x] = vregs[y];
        batch.push_back(make_write(DEST_REG, x, vregs[x], '0));
      end
      FUNC_FONT: begin
        index_reg = ADDR_W'(FONT_BASE + 5 * int'(vregs[x][3:0]));
        batch.push_back(make_write(DEST_IDX, x, '0, '0));
      end
      FUNC_PDUMP: begin
        for (k = 0; k <= x; k++) begin
          pflags[k] = vregs[k];
          batch.push_back(make_write(DEST_FLAG, NIB_W'(k), vregs[k], '0));
        end
      end
      FUNC_PLOAD: begin
        for (k = 0; k <= x; k++) begin
          vregs[k] = pflags[k];
          batch.push_back(make_write(DEST_REG, NIB_W'(k), vregs[k], '0));
        end
      end
      FUNC_HOST: begin
        memory[haddr % MEM_DEPTH] = hdata;
        batch.push_back(make_write(DEST_MEM, '0, hdata, haddr));
      end
      default: begin
        // spare codes: dropped without a trace
      end
    endcase
    // I is reported as it stands after the whole command
    for (k = 0; k < batch.size(); k++) begin
      w             = batch[k];
      w.index_value = index_reg;
      w.last        = (k == batch.size() - 1);
      expected_writes.push_back(w);
    end
  endtask

  // Compare first, then predict: results of a command trail its acceptance
  always @(posedge clk_i) begin
    write_rec_t got;
    write_rec_t want;
    if (!rst_ni) begin
      foreach (vregs[k]) vregs[k] = '0;
      foreach (pflags[k]) pflags[k] = '0;
      foreach (memory[k]) memory[k] = '0;
      index_reg = '0;
      expected_writes.delete();
      fail_count_o = 0;
    end else begin
      if (result_valid_i) begin
        got.dest        = dest_e'(dest_i);
        got.reg_num     = reg_num_i;
        got.value       = value_i;
        got.mem_addr    = mem_addr_i;
        got.index_value = index_value_i;
        got.last        = last_i;
        if (expected_writes.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: unexpected result word dest=%0d reg=%0d value=%02h",
                     $realtime, got.dest, got.reg_num, got.value);
        end else begin
          want = expected_writes.pop_front();
          if (got.dest !== want.dest || got.reg_num !== want.reg_num ||
              got.value !== want.value || got.mem_addr !== want.mem_addr ||
              got.index_value !== want.index_value || got.last !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS)
              $display({"%0t: result mismatch, expected dest=%0d reg=%0d value=%02h ",
                        "addr=%03h idx=%03h last=%0d, got dest=%0d reg=%0d ",
                        "value=%02h addr=%03h idx=%03h last=%0d"},
                       $realtime, want.dest, want.reg_num, want.value,
                       want.mem_addr, want.index_value, want.last,
                       got.dest, got.reg_num, got.value, got.mem_addr,
                       got.index_value, got.last);
          end
        end
      end
      if (start_i && !busy_i)
        predict_writes(func_i, instr_word_i, host_addr_i, host_data_i);
    end
    pending_o = expected_writes.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Testbench top for the CHIP-8 register transfer unit. Drives a directed set
// of commands covering every operation, address wrap and the spare codes,
// then a few hundred weighted random commands with random idle bursts. The
// checker beside the block predicts and compares every result word.
// ============================================================================
module tb;
  import c8rtu_pkg::*;

  localparam int RANDOM_ITEMS  = 300;
  localparam int CALM_TAIL     = 60;
  localparam int STALL_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 40;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = FUNC_HOST + 1'b1;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = '1;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic [FUNC_W-1:0] func_i       = '0;
  logic [WORD_W-1:0] instr_word_i = '0;
  logic [ADDR_W-1:0] host_addr_i  = '0;
  logic [BYTE_W-1:0] host_data_i  = '0;
  logic              busy;
  logic              result_valid_o;
  logic [DEST_W-1:0] dest_o;
  logic [NIB_W-1:0]  reg_num_o;
  logic [BYTE_W-1:0] value_o;
  logic [ADDR_W-1:0] mem_addr_o;
  logic [ADDR_W-1:0] index_value_o;
  logic              last_o;
  int                fail_count;
  int                pending;
  int                stall_cycles = 0;

  chip8_register_transfer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .instr_word_i  (instr_word_i),
    .host_addr_i   (host_addr_i),
    .host_data_i   (host_data_i),
    .result_valid_o(result_valid_o),
    .dest_o        (dest_o),
    .reg_num_o     (reg_num_o),
    .value_o       (value_o),
    .mem_addr_o    (mem_addr_o),
    .index_value_o (index_value_o),
    .last_o        (last_o)
  );

  chip8_register_transfer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .func_i        (func_i),
    .instr_word_i  (instr_word_i),
    .host_addr_i   (host_addr_i),
    .host_data_i   (host_data_i),
    .result_valid_i(result_valid_o),
    .dest_i        (dest_o),
    .reg_num_i     (reg_num_o),
    .value_i       (value_o),
    .mem_addr_i    (mem_addr_o),
    .index_value_i (index_value_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles with no traffic on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog: the reset memory sweep is well inside the limit
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Present one command word and hold it until the block takes it
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [WORD_W-1:0] w,
                           input logic [ADDR_W-1:0] ha, input logic [BYTE_W-1:0] hd);
    start        <= 1'b1;
    func_i       <= fn;
    instr_word_i <= w;
    host_addr_i  <= ha;
    host_data_i  <= hd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start for a random burst
  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic [FUNC_W-1:0] fn;
    logic [WORD_W-1:0] w;
    int                pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every operation, wrap, spare codes
    send_word(FUNC_SETREG, 16'h60FF, 12'h000, 8'h00);
    send_word(FUNC_SETREG, 16'h6FA5, 12'hFFF, 8'hFF);
    send_word(FUNC_SETREG, 16'h63BF, 12'h555, 8'h55);
    send_word(FUNC_SETREG, 16'h62F0, 12'hAAA, 8'hAA);
    send_word(FUNC_FONT, 16'hF329, 12'h000, 8'h00);
    send_word(FUNC_FONT, 16'hF229, 12'h000, 8'h00);
    send_word(FUNC_MOVE, 16'h81F0, 12'h000, 8'h00);
    send_word(FUNC_SETIDX, 16'hAFFE, 12'h000, 8'h00);
    send_word(FUNC_DUMP, 16'hFF55, 12'h000, 8'h00);
    send_word(FUNC_SETIDX, 16'hAFFE, 12'h000, 8'h00);
    send_word(FUNC_LOADN, 16'hF265, 12'h000, 8'h00);
    send_word(FUNC_LOAD, 16'hFF65, 12'h000, 8'h00);
    send_word(FUNC_DUMPN, 16'hF055, 12'h000, 8'h00);
    send_word(FUNC_PDUMP, 16'hFF75, 12'h000, 8'h00);
    send_word(FUNC_SETREG, 16'h6000, 12'h000, 8'h00);
    send_word(FUNC_PLOAD, 16'hF085, 12'h000, 8'h00);
    send_word(FUNC_PLOAD, 16'hFF85, 12'h000, 8'h00);
    send_word(FUNC_PDUMP, 16'hF075, 12'h000, 8'h00);
    send_word(FUNC_HOST, 16'h0000, 12'hFFF, 8'hFF);
    send_word(FUNC_HOST, 16'hFFFF, 12'h000, 8'h00);
    send_word(FUNC_SETIDX, 16'hAFFF, 12'h000, 8'h00);
    send_word(FUNC_LOAD, 16'hF165, 12'h000, 8'h00);
    send_word(FUNC_SPARE_FIRST, 16'hFFFF, 12'hFFF, 8'hFF);
    send_word(FUNC_SPARE_LAST, 16'h0000, 12'h000, 8'h00);

    // Random: weighted toward transfers so memory and flags carry data
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      w    = 16'($urandom);
      if (pick < 18)      fn = FUNC_SETREG;
      else if (pick < 28) fn = FUNC_SETIDX;
      else if (pick < 37) fn = FUNC_DUMP;
      else if (pick < 43) fn = FUNC_DUMPN;
      else if (pick < 52) fn = FUNC_LOAD;
      else if (pick < 58) fn = FUNC_LOADN;
      else if (pick < 66) fn = FUNC_MOVE;
      else if (pick < 72) fn = FUNC_FONT;
      else if (pick < 78) fn = FUNC_PDUMP;
      else if (pick < 84) fn = FUNC_PLOAD;
      else if (pick < 96) fn = FUNC_HOST;
      else fn = FUNC_SPARE_FIRST + FUNC_W'($urandom_range(0, 4));
      // steer I near the top so transfers wrap often
      if (fn == FUNC_SETIDX && $urandom_range(0, 2) == 0)
        w[ADDR_W-1:0] = 12'hFF0 | ADDR_W'($urandom_range(0, 15));
      send_word(fn, w, ADDR_W'($urandom), BYTE_W'($urandom));
      if (n == RANDOM_ITEMS / 2) begin
        // hold off until the block has reported everything
        start <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end else if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        idle_burst();
      end
    end
    start <= 1'b0;

    // Drain and give the verdict
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
